@@ design/rgb_hsv_pixel_converter_top_assert.svh @@
// Assertion macros shared by the converter's checker.
`ifndef RGB_HSV_PIXEL_CONVERTER_TOP_ASSERT_SVH
`define RGB_HSV_PIXEL_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RHC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RHC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/rhc_pkg.sv @@
// Types, constants and request codes of the RGB/HSB pixel converter.
package rhc_pkg;

	localparam int CH_W = 8;                 // channel width
	localparam int FR_W = 16;                // fraction bits of the fixed point
	localparam int LIM = (1 << CH_W) - 1;    // full-scale channel value

	localparam int SEXTANTS = 6;
	localparam int GREEN_BASE = 2;
	localparam int BLUE_BASE = 4;

	localparam int HS_W = FR_W + 3;          // sextant value, up to 6.0
	localparam int SN_W = FR_W + 1;          // normalized saturation, up to 1.0
	localparam int MUL_W = 2 * FR_W + 1;     // products of two Q.F values, up to 1.0
	localparam int NUM_W = CH_W + FR_W;      // divider dividend
	localparam int Q_W = FR_W + 1;           // divider quotient

	localparam int DIV_BPS = 4;
	localparam int DIV_STAGES = (Q_W + DIV_BPS - 1) / DIV_BPS;
	localparam int LATENCY = DIV_STAGES + 5;

	// Divide by LIM: multiply by the rounded-up reciprocal, exact for
	// dividends below 6 * LIM * 2^FR_W.
	localparam int RCP_K = 2 * CH_W + 3 + FR_W;
	localparam int RCP_W = RCP_K - CH_W + 1;
	localparam int RCP_SH = RCP_K - FR_W;
	localparam longint unsigned RCP_M = ((64'd1 << RCP_K) + LIM - 1) / LIM;

	// Divide by three for values below 2048.
	localparam int THIRD_M = 683;
	localparam int THIRD_SH = 11;
	localparam int HY_W = CH_W + 2;

	typedef enum logic [2:0] {
		REQ_RGB2HSB = 3'd0,
		REQ_HSB2RGB = 3'd1,
		REQ_SET_HUE = 3'd2,
		REQ_SET_SAT = 3'd3,
		REQ_SET_BRI = 3'd4
	} req_code_t;

	typedef enum logic [1:0] {
		SEC_RED,
		SEC_GREEN,
		SEC_BLUE
	} sector_t;

	typedef struct packed {
		logic [2:0]      req_type;
		logic [CH_W-1:0] comp_a;
		logic [CH_W-1:0] comp_b;
		logic [CH_W-1:0] comp_c;
		logic [CH_W-1:0] new_value;
	} rhc_item_t;

	typedef struct packed {
		logic [CH_W-1:0] out_a;
		logic [CH_W-1:0] out_b;
		logic [CH_W-1:0] out_c;
		logic            is_gray;
	} rhc_result_t;

	// Side data that rides next to the dividers.
	typedef struct packed {
		logic [2:0]      req;
		logic [CH_W-1:0] mx;
		logic [CH_W-1:0] comp_c;
		logic [CH_W-1:0] new_value;
		sector_t         sector;
		logic            neg;
		logic            gray;
		logic [HS_W-1:0] hs_in;
		logic [SN_W-1:0] sn_in;
	} rhc_side_t;

endpackage

@@ design/rhc_div_pipe.sv @@
// Pipelined restoring divider, BPS quotient bits per stage.
module rhc_div_pipe #(
	parameter int NUM_W = rhc_pkg::NUM_W,
	parameter int DEN_W = rhc_pkg::CH_W,
	parameter int Q_W = rhc_pkg::Q_W,
	parameter int BPS = rhc_pkg::DIV_BPS
) (
	input  logic             clk,
	input  logic [NUM_W-1:0] num,
	input  logic [DEN_W-1:0] den,
	output logic [Q_W-1:0]   quo
);
	// Dividend must stay below den * 2^Q_W.
	localparam int STAGES = (Q_W + BPS - 1) / BPS;
	localparam int QP = STAGES * BPS;
	localparam int NX_W = QP + DEN_W;

	logic [NX_W-1:0]  num_x;
	logic [DEN_W-1:0] rem_s [STAGES];
	logic [QP-1:0]    low_s [STAGES];
	logic [QP-1:0]    quo_s [STAGES];
	logic [DEN_W-1:0] den_s [STAGES];

	assign num_x = NX_W'(num);

	for (genvar g = 0; g < STAGES; g++) begin : g_stage
		logic [DEN_W-1:0] r_in, r_nx;
		logic [QP-1:0]    l_in, l_nx, q_in, q_nx;
		logic [DEN_W-1:0] d_in;

		if (g == 0) begin : g_first
			assign r_in = num_x[QP +: DEN_W];
			assign l_in = num_x[QP-1:0];
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[g-1];
			assign l_in = low_s[g-1];
			assign q_in = quo_s[g-1];
			assign d_in = den_s[g-1];
		end

		always_comb begin
			logic [DEN_W:0] t;
			r_nx = r_in;
			l_nx = l_in;
			q_nx = q_in;
			for (int i = 0; i < BPS; i++) begin
				t = {r_nx, l_nx[QP-1]};
				l_nx = l_nx << 1;
				if (t >= {1'b0, d_in}) begin
					r_nx = DEN_W'(t - {1'b0, d_in});
					q_nx = {q_nx[QP-2:0], 1'b1};
				end else begin
					r_nx = t[DEN_W-1:0];
					q_nx = {q_nx[QP-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			rem_s[g] <= r_nx;
			low_s[g] <= l_nx;
			quo_s[g] <= q_nx;
			den_s[g] <= d_in;
		end
	end

	assign quo = quo_s[STAGES-1][Q_W-1:0];

endmodule

@@ design/rgb_hsv_pixel_converter_top.sv @@
// Top level of the pipelined RGB/HSB pixel converter.
//
// Usage:
//   Drive item and raise start for one cycle per pixel; a transaction is
//   accepted at each rising edge with start high and busy low. busy stays
//   low, so a new pixel can enter on every clock.
//   req_type picks RGB to HSB, HSB to RGB, or one of the set-hue,
//   set-saturation, set-brightness adjustments (RGB in, RGB out).
//   Each accepted transaction produces exactly one result, shown on result
//   for one cycle with result_valid high, in input order.
// Throughput: one pixel per clock. Latency is set by the three pipelined
//   dividers (4 quotient bits per stage, 5 stages) plus the input stage and
//   four stages of multiply and select.
// Reset: arst_n clears the valid pipeline at once; pixels in flight are
//   dropped and no result strobes until new transactions arrive.
// The receiver cannot stall: results must be taken when result_valid is high.
module rgb_hsv_pixel_converter_top (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  rhc_pkg::rhc_item_t   item,
	output logic                 result_valid,
	output rhc_pkg::rhc_result_t result
);
	import rhc_pkg::*;

	localparam int HP_W = CH_W + 3 + RCP_W;   // hue reciprocal product
	localparam int SP_W = CH_W + RCP_W;       // saturation reciprocal product

	// Valid bits, one per stage; bit k belongs to stage k+1.
	logic [LATENCY-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= {vld_s[LATENCY-2:0], start};
		end
	end

	assign busy = 1'b0;
	assign result_valid = vld_s[LATENCY-1];

	// Stage 1: capture the transaction.
	rhc_item_t item_s1;

	always_ff @(posedge clk) begin
		item_s1 <= item;
	end

	// Stage 1 logic: max/min, hue sector, divider operands, and the
	// reciprocal multiplies for hue and saturation coming from inputs.
	logic [CH_W-1:0]  r1, g1, b1, mx1, mn1, d1, x1;
	logic [CH_W-1:0]  h_sel, s_sel;
	logic [CH_W+2:0]  h6;
	logic [HP_W-1:0]  hs_prod;
	logic [SP_W-1:0]  sn_prod;
	logic [2*CH_W-1:0] sat_num;
	rhc_side_t        side1;

	always_comb begin
		r1 = item_s1.comp_a;
		g1 = item_s1.comp_b;
		b1 = item_s1.comp_c;
		mx1 = r1;
		mn1 = r1;
		if (g1 > mx1) mx1 = g1;
		if (b1 > mx1) mx1 = b1;
		if (g1 < mn1) mn1 = g1;
		if (b1 < mn1) mn1 = b1;
		d1 = mx1 - mn1;

		side1.sector = SEC_BLUE;
		side1.neg = 1'b0;
		x1 = '0;
		priority if (r1 == mx1) begin
			side1.sector = SEC_RED;
			side1.neg = (g1 < b1);
			x1 = (g1 >= b1) ? g1 - b1 : b1 - g1;
		end else if (g1 == mx1) begin
			side1.sector = SEC_GREEN;
			side1.neg = (b1 < r1);
			x1 = (b1 >= r1) ? b1 - r1 : r1 - b1;
		end else begin
			side1.sector = SEC_BLUE;
			side1.neg = (r1 < g1);
			x1 = (r1 >= g1) ? r1 - g1 : g1 - r1;
		end

		h_sel = (item_s1.req_type == REQ_HSB2RGB) ? item_s1.comp_a : item_s1.new_value;
		s_sel = (item_s1.req_type == REQ_HSB2RGB) ? item_s1.comp_b : item_s1.new_value;
		h6 = (CH_W+3)'(h_sel) * (CH_W+3)'(SEXTANTS);
		hs_prod = HP_W'(h6) * HP_W'(RCP_M);
		sn_prod = SP_W'(s_sel) * SP_W'(RCP_M);

		side1.req = item_s1.req_type;
		side1.mx = mx1;
		side1.comp_c = item_s1.comp_c;
		side1.new_value = item_s1.new_value;
		side1.gray = (mx1 == mn1);
		side1.hs_in = HS_W'(hs_prod >> RCP_SH);
		side1.sn_in = SN_W'(sn_prod >> RCP_SH);

		sat_num = {d1, CH_W'(0)} - {CH_W'(0), d1};
	end

	// Stages 2..6: three dividers in parallel; side data rides alongside.
	logic [Q_W-1:0] hsq_q, snq_q, satq_q;

	rhc_div_pipe #(.NUM_W(NUM_W), .DEN_W(CH_W), .Q_W(Q_W), .BPS(DIV_BPS)) u_div_hue (
		.clk (clk),
		.num ({x1, FR_W'(0)}),
		.den (d1),
		.quo (hsq_q)
	);

	rhc_div_pipe #(.NUM_W(NUM_W), .DEN_W(CH_W), .Q_W(Q_W), .BPS(DIV_BPS)) u_div_sn (
		.clk (clk),
		.num ({d1, FR_W'(0)}),
		.den (mx1),
		.quo (snq_q)
	);

	rhc_div_pipe #(.NUM_W(NUM_W), .DEN_W(CH_W), .Q_W(Q_W), .BPS(DIV_BPS)) u_div_sat (
		.clk (clk),
		.num (NUM_W'(sat_num)),
		.den (mx1),
		.quo (satq_q)
	);

	rhc_side_t side_dly_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		side_dly_s[0] <= side1;
		for (int i = 1; i < DIV_STAGES; i++) begin
			side_dly_s[i] <= side_dly_s[i-1];
		end
	end

	// Stage 6 logic: rebuild the sextant value, pick the operands of the
	// HSB to RGB step. Gray pixels force the hue and saturation computed from RGB to zero.
	rhc_side_t       sd6;
	logic [HS_W-1:0] base6, hs_calc, hs6;
	logic [SN_W-1:0] sn_calc, sn6;
	logic [CH_W-1:0] sat_calc, v6;

	always_comb begin
		sd6 = side_dly_s[DIV_STAGES-1];
		unique case (sd6.sector)
			SEC_RED:   base6 = sd6.neg ? HS_W'(SEXTANTS) << FR_W : '0;
			SEC_GREEN: base6 = HS_W'(GREEN_BASE) << FR_W;
			default:   base6 = HS_W'(BLUE_BASE) << FR_W;
		endcase
		hs_calc = sd6.neg ? base6 - HS_W'(hsq_q) : base6 + HS_W'(hsq_q);
		sn_calc = snq_q;
		sat_calc = satq_q[CH_W-1:0];
		if (sd6.gray) begin
			hs_calc = '0;
			sn_calc = '0;
			sat_calc = '0;
		end

		hs6 = hs_calc;
		sn6 = sn_calc;
		v6 = sd6.mx;
		unique case (sd6.req)
			REQ_RGB2HSB: begin
			end
			REQ_HSB2RGB: begin
				hs6 = sd6.hs_in;
				sn6 = sd6.sn_in;
				v6 = sd6.comp_c;
			end
			REQ_SET_HUE: hs6 = sd6.hs_in;
			REQ_SET_SAT: sn6 = sd6.sn_in;
			REQ_SET_BRI: v6 = sd6.new_value;
			default: begin
				hs6 = '0;
				sn6 = '0;
				v6 = '0;
			end
		endcase
	end

	// Stage 7 registers.
	logic [HS_W-1:0] hs_s7;
	logic [SN_W-1:0] sn_s7;
	logic [CH_W-1:0] v_s7, sat_s7;
	logic            gray_s7;
	logic [2:0]      req_s7;

	always_ff @(posedge clk) begin
		hs_s7 <= hs6;
		sn_s7 <= sn6;
		v_s7 <= v6;
		sat_s7 <= sat_calc;
		gray_s7 <= sd6.gray;
		req_s7 <= sd6.req;
	end

	// Stage 7 logic: saturation times fraction products, p term, hue scale.
	logic [FR_W-1:0]      f7;
	logic [SN_W-1:0]      nf7, nsn7;
	logic [MUL_W-1:0]     snf7, snnf7;
	logic [SN_W+CH_W-1:0] p_prod7;
	logic [HS_W+CH_W-1:0] hue255;

	always_comb begin
		f7 = hs_s7[FR_W-1:0];
		nf7 = (SN_W'(1) << FR_W) - SN_W'(f7);
		nsn7 = (SN_W'(1) << FR_W) - sn_s7;
		snf7 = MUL_W'(sn_s7) * MUL_W'(f7);
		snnf7 = MUL_W'(MUL_W'(sn_s7) * MUL_W'(nf7));
		p_prod7 = (SN_W+CH_W)'(nsn7) * (SN_W+CH_W)'(v_s7);
		hue255 = ((HS_W+CH_W)'(hs_s7) << CH_W) - (HS_W+CH_W)'(hs_s7);
	end

	// Stage 8 registers.
	logic [2:0]       cat_s8;
	logic [MUL_W-1:0] snf_s8, snnf_s8;
	logic [CH_W-1:0]  p_s8, v_s8, sat_s8;
	logic [HY_W-1:0]  hy_s8;
	logic             snz_s8, gray_s8;
	logic [2:0]       req_s8;

	always_ff @(posedge clk) begin
		cat_s8 <= hs_s7[HS_W-1:FR_W];
		snf_s8 <= snf7;
		snnf_s8 <= snnf7;
		p_s8 <= CH_W'(p_prod7 >> FR_W);
		v_s8 <= v_s7;
		sat_s8 <= sat_s7;
		hy_s8 <= HY_W'(hue255 >> (FR_W + 1));
		snz_s8 <= (sn_s7 == '0);
		gray_s8 <= gray_s7;
		req_s8 <= req_s7;
	end

	// Stage 8 logic: q and t terms, hue divided by three.
	localparam int QT_W = MUL_W + CH_W;

	logic [QT_W-1:0]   q_prod8, t_prod8;
	logic [2*HY_W-1:0] hue_prod8;

	always_comb begin
		q_prod8 = QT_W'((MUL_W'(1) << (2 * FR_W)) - snf_s8) * QT_W'(v_s8);
		t_prod8 = QT_W'((MUL_W'(1) << (2 * FR_W)) - snnf_s8) * QT_W'(v_s8);
		hue_prod8 = (2*HY_W)'(hy_s8) * (2*HY_W)'(THIRD_M);
	end

	// Stage 9 registers.
	logic [CH_W-1:0] q_s9, t_s9, p_s9, v_s9, sat_s9, hue_s9;
	logic [2:0]      cat_s9, req_s9;
	logic            snz_s9, gray_s9;

	always_ff @(posedge clk) begin
		q_s9 <= CH_W'(q_prod8 >> (2 * FR_W));
		t_s9 <= CH_W'(t_prod8 >> (2 * FR_W));
		p_s9 <= p_s8;
		v_s9 <= v_s8;
		sat_s9 <= sat_s8;
		hue_s9 <= CH_W'(hue_prod8 >> THIRD_SH);
		cat_s9 <= cat_s8;
		req_s9 <= req_s8;
		snz_s9 <= snz_s8;
		gray_s9 <= gray_s8;
	end

	// Stage 9 logic: black and gray branches, sextant table, output mux.
	rhc_result_t res9;

	always_comb begin
		res9 = '0;
		unique case (req_s9)
			REQ_RGB2HSB: begin
				res9.out_a = hue_s9;
				res9.out_b = sat_s9;
				res9.out_c = v_s9;
				res9.is_gray = gray_s9;
			end
			REQ_HSB2RGB, REQ_SET_HUE, REQ_SET_SAT, REQ_SET_BRI: begin
				priority if (v_s9 == '0) begin
					res9.is_gray = 1'b1;
				end else if (snz_s9) begin
					res9.out_a = v_s9;
					res9.out_b = v_s9;
					res9.out_c = v_s9;
					res9.is_gray = 1'b1;
				end else begin
					unique case (cat_s9)
						3'd1: begin
							res9.out_a = q_s9; res9.out_b = v_s9; res9.out_c = p_s9;
						end
						3'd2: begin
							res9.out_a = p_s9; res9.out_b = v_s9; res9.out_c = t_s9;
						end
						3'd3: begin
							res9.out_a = p_s9; res9.out_b = q_s9; res9.out_c = v_s9;
						end
						3'd4: begin
							res9.out_a = t_s9; res9.out_b = p_s9; res9.out_c = v_s9;
						end
						3'd5: begin
							res9.out_a = v_s9; res9.out_b = p_s9; res9.out_c = q_s9;
						end
						// sextant 0, and 6 wrapping around to 0
						default: begin
							res9.out_a = v_s9; res9.out_b = t_s9; res9.out_c = p_s9;
						end
					endcase
				end
			end
			// unused request codes give an all-zero result
			default: res9 = '0;
		endcase
	end

	// Stage 10: output register; result_valid marks when it holds a result.
	always_ff @(posedge clk) begin
		result <= res9;
	end

endmodule

@@ design/rhc_checker.sv @@
// Port-level checker for the RGB/HSB converter, bound to the top level.
`include "rgb_hsv_pixel_converter_top_assert.svh"

module rhc_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 start,
	input logic                 busy,
	input rhc_pkg::rhc_item_t   item,
	input logic                 result_valid,
	input rhc_pkg::rhc_result_t result
);
	import rhc_pkg::*;

	localparam int CNT_W = $clog2(LATENCY + 1);

	// Count edges since reset so history older than reset is ignored.
	logic [CNT_W-1:0] warm_q;
	logic             warm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
		end else if (warm_q != CNT_W'(LATENCY)) begin
			warm_q <= warm_q + 1'b1;
		end
	end

	assign warm = (warm_q == CNT_W'(LATENCY));

	`RHC_ASSERT_NOW(a_busy_low, 1'b1, !busy, "busy raised on a stall-free pipeline")
	`RHC_ASSERT_NOW(a_one_result, warm, result_valid == $past(start, LATENCY), "result strobe does not match a transaction LATENCY cycles back")
	`RHC_ASSERT_NOW(a_unused_zero, warm && $past(start && (item.req_type > 3'(REQ_SET_BRI)), LATENCY), result == '0, "unused request code gave a nonzero result")
	`RHC_ASSERT_NOW(a_gray_hsb, warm && result.is_gray && $past(start && (item.req_type == REQ_RGB2HSB), LATENCY), (result.out_a == '0) && (result.out_b == '0), "gray pixel has nonzero hue or saturation")
	`RHC_ASSERT_NOW(a_gray_rgb, warm && result.is_gray && $past(start && (item.req_type != REQ_RGB2HSB) && (item.req_type <= 3'(REQ_SET_BRI)), LATENCY), (result.out_a == result.out_b) && (result.out_b == result.out_c), "gray RGB result has unequal channels")

endmodule

bind rgb_hsv_pixel_converter_top rhc_checker u_rhc_checker (.*);
